### hdl/dmc_pkg.sv
// Shared types and constants of the depth-first maze carver.
// Used by dmc_ctrl, dmc_datapath and dfs_maze_carver; depends on nothing.
`default_nettype none

package dmc_pkg;

	// Default grid limits
	localparam int DMC_MAX_WIDTH  = 64;
	localparam int DMC_MAX_HEIGHT = 64;

	// Register indexes of the configuration port
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// Size written at reset
	localparam logic [6:0] REG_RESET_DIM = 7'd16;

	// Parent code of a cell that has no way back
	localparam logic [2:0] PARENT_NONE = 3'd7;

	// Request codes
	localparam logic REQ_START = 1'b0;

	// Direction codes
	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	// Datapath commands
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_START,
		OP_CLEAR,
		OP_MOVE_RD,
		OP_MOVE_RDC,
		OP_MOVE_WRC,
		OP_MOVE_WRN,
		OP_BT_RD,
		OP_BT_RDC,
		OP_BT_STEP,
		OP_SET_DONE,
		OP_LOAD_OUT
	} op_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLEAR_RST,
		ST_IDLE,
		ST_DISPATCH,
		ST_CLEAR,
		ST_MOVE_CHK,
		ST_MOVE_WRC,
		ST_MOVE_WRN,
		ST_BT_TOP,
		ST_BT_NB,
		ST_BT_STEP,
		ST_FINISH
	} state_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_start;
		logic done;
		logic clear_last;
		logic rd_visited;
		logic guard_zero;
		logic at_origin;
		logic parent_bad;
		logic k_wrap;
	} stat_t;

endpackage

`default_nettype wire

### hdl/dmc_datapath.sv
// Datapath of the maze carver: cell store, walker, exits, result registers.
// Driven by dmc_ctrl through op_t commands; uses dmc_pkg.
`default_nettype none

module dmc_datapath
	import dmc_pkg::*;
#(
	parameter int MAX_WIDTH  = DMC_MAX_WIDTH,
	parameter int MAX_HEIGHT = DMC_MAX_HEIGHT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire op_t        op,
	output stat_t           stat,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [6:0] cfg_data,
	input  wire logic       in_req_type,
	input  wire logic [1:0] in_direction,
	output logic            move_accepted,
	output logic [5:0]      from_x,
	output logic [5:0]      from_y,
	output logic [1:0]      carved_dir,
	output logic            maze_done,
	output logic [5:0]      exit_x,
	output logic [5:0]      exit_y
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int DW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int GW    = $clog2(CELLS + 2);
	localparam logic [AW-1:0] ROW_LEN   = AW'(MAX_WIDTH);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	// Clamp a register value into 2..limit
	function automatic logic [8:0] clamp_dim(input logic [6:0] v, input logic [8:0] limit);
		logic [8:0] v9;
		logic [8:0] r;
		v9 = {2'b00, v};
		if (v9 < 9'd2) begin
			r = 9'd2;
		end else if (v9 > limit) begin
			r = limit;
		end else begin
			r = v9;
		end
		return r;
	endfunction

	// Column after one step, held at the edge
	function automatic logic [XW-1:0] step_x(input logic [XW-1:0] x, input logic [1:0] d,
			input logic [DW-1:0] w);
		logic [XW-1:0] r;
		r = x;
		if (d == DIR_RIGHT) begin
			if (DW'(x) + DW'(1) < w) r = x + XW'(1);
		end else if (d == DIR_LEFT) begin
			if (x != '0) r = x - XW'(1);
		end
		return r;
	endfunction

	// Row after one step, held at the edge
	function automatic logic [YW-1:0] step_y(input logic [YW-1:0] y, input logic [1:0] d,
			input logic [HW-1:0] h);
		logic [YW-1:0] r;
		r = y;
		if (d == DIR_UP) begin
			if (y != '0) r = y - YW'(1);
		end else if (d == DIR_DOWN) begin
			if (HW'(y) + HW'(1) < h) r = y + YW'(1);
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
		return AW'(y) * ROW_LEN + AW'(x);
	endfunction

	// Configuration and latched grid size
	logic [6:0]    gw_q, gh_q;
	logic [DW-1:0] act_w_q;
	logic [HW-1:0] act_h_q;
	logic [GW-1:0] area_q;

	// Walker and control registers
	logic          req_q;
	logic [1:0]    dir_q;
	logic [XW-1:0] cur_x_q, nx_q;
	logic [YW-1:0] cur_y_q, ny_q;
	logic [GW-1:0] guard_q;
	logic [1:0]    k_q;
	logic [AW-1:0] clr_addr_q;
	logic          done_q, rev_q, dev_q;
	logic [XW-1:0] rex_q, dex_q;
	logic [YW-1:0] rey_q, dey_q;

	// Per-item result
	logic          res_acc_q;
	logic [XW-1:0] res_fx_q;
	logic [YW-1:0] res_fy_q;
	logic [1:0]    res_cd_q;

	// Cell store: [7:5] parent, [4] visited, [3:0] passages
	logic [7:0] mem [CELLS];
	logic [7:0] rdata_q, nword_q;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [1:0]    sel_dir;
	logic [XW-1:0] nb_x, par_x, ex_x;
	logic [YW-1:0] nb_y, par_y, ex_y;
	logic [1:0]    back_dir;
	logic [2:0]    new_parent;
	logic [XW+5:0] pad_fx, pad_ex;
	logic [YW+5:0] pad_fy, pad_ey;

	// Neighbor and parent steps
	always_comb begin
		sel_dir    = (op == OP_BT_RD) ? k_q : dir_q;
		nb_x       = step_x(cur_x_q, sel_dir, act_w_q);
		nb_y       = step_y(cur_y_q, sel_dir, act_h_q);
		par_x      = step_x(cur_x_q, rdata_q[6:5], act_w_q);
		par_y      = step_y(cur_y_q, rdata_q[6:5], act_h_q);
		back_dir   = dir_q ^ 2'b01;
		new_parent = (nword_q[7:5] == PARENT_NONE) ? {1'b0, back_dir} : nword_q[7:5];
	end

	// Drive the store port
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = cell_addr(cur_x_q, cur_y_q);
		mem_wdata = rdata_q;
		case (op)
			OP_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_addr_q;
				mem_wdata = {PARENT_NONE, (clr_addr_q == '0), 4'b0000};
			end
			OP_MOVE_RD, OP_BT_RD: begin
				mem_re   = 1'b1;
				mem_addr = cell_addr(nb_x, nb_y);
			end
			OP_MOVE_RDC, OP_BT_RDC: begin
				mem_re = 1'b1;
			end
			OP_MOVE_WRC: begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q | (8'd1 << dir_q);
			end
			OP_MOVE_WRN: begin
				mem_we    = 1'b1;
				mem_addr  = cell_addr(nx_q, ny_q);
				mem_wdata = {new_parent, 1'b1, nword_q[3:0] | (4'd1 << back_dir)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q       <= REG_RESET_DIM;
			gh_q       <= REG_RESET_DIM;
			act_w_q    <= DW'(clamp_dim(REG_RESET_DIM, 9'(MAX_WIDTH)));
			act_h_q    <= HW'(clamp_dim(REG_RESET_DIM, 9'(MAX_HEIGHT)));
			req_q      <= 1'b0;
			dir_q      <= 2'b00;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			guard_q    <= '0;
			k_q        <= 2'b00;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
			rev_q      <= 1'b0;
			dev_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_GRID_WIDTH) gw_q <= cfg_data;
				if (cfg_index == REG_GRID_HEIGHT) gh_q <= cfg_data;
			end
			case (op)
				OP_ACCEPT: begin
					req_q <= in_req_type;
					dir_q <= in_direction;
				end
				OP_START: begin
					act_w_q    <= DW'(clamp_dim(gw_q, 9'(MAX_WIDTH)));
					act_h_q    <= HW'(clamp_dim(gh_q, 9'(MAX_HEIGHT)));
					cur_x_q    <= '0;
					cur_y_q    <= '0;
					clr_addr_q <= '0;
					done_q     <= 1'b0;
					rev_q      <= 1'b0;
					dev_q      <= 1'b0;
				end
				OP_CLEAR: clr_addr_q <= clr_addr_q + AW'(1);
				OP_MOVE_WRN: begin
					cur_x_q <= nx_q;
					cur_y_q <= ny_q;
					guard_q <= area_q + GW'(1);
					k_q     <= 2'b00;
				end
				OP_BT_RD: k_q <= k_q + 2'd1;
				OP_BT_RDC: guard_q <= guard_q - GW'(1);
				OP_SET_DONE: done_q <= 1'b1;
				OP_BT_STEP: begin
					if (DW'(cur_x_q) == act_w_q - DW'(1) && $onehot(rdata_q[3:0])) rev_q <= 1'b1;
					dev_q <= 1'b1;
					if (rdata_q[7]) begin
						done_q <= 1'b1;
					end else begin
						cur_x_q <= par_x;
						cur_y_q <= par_y;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Chosen exit
	always_comb begin
		ex_x = '0;
		ex_y = '0;
		if (rev_q) begin
			ex_x = rex_q;
			ex_y = rey_q;
		end else if (dev_q) begin
			ex_x = dex_q;
			ex_y = dey_q;
		end
		pad_fx = {6'b0, res_fx_q};
		pad_fy = {6'b0, res_fy_q};
		pad_ex = {6'b0, ex_x};
		pad_ey = {6'b0, ex_y};
	end

	// Payload registers
	always_ff @(posedge clk) begin
		area_q <= GW'(act_w_q) * GW'(act_h_q);
		case (op)
			OP_ACCEPT: begin
				res_acc_q <= 1'b0;
				res_fx_q  <= '0;
				res_fy_q  <= '0;
				res_cd_q  <= 2'b00;
			end
			OP_MOVE_RD: begin
				res_fx_q <= cur_x_q;
				res_fy_q <= cur_y_q;
				nx_q     <= nb_x;
				ny_q     <= nb_y;
			end
			OP_MOVE_RDC: nword_q <= rdata_q;
			OP_MOVE_WRN: begin
				res_acc_q <= 1'b1;
				res_cd_q  <= dir_q;
			end
			OP_BT_STEP: begin
				if (DW'(cur_x_q) == act_w_q - DW'(1) && $onehot(rdata_q[3:0])) begin
					rex_q <= cur_x_q;
					rey_q <= cur_y_q;
				end
				if (!dev_q) begin
					dex_q <= cur_x_q;
					dey_q <= cur_y_q;
				end
			end
			OP_LOAD_OUT: begin
				move_accepted <= res_acc_q;
				from_x        <= pad_fx[5:0];
				from_y        <= pad_fy[5:0];
				carved_dir    <= res_cd_q;
				maze_done     <= done_q;
				exit_x        <= done_q ? pad_ex[5:0] : 6'd0;
				exit_y        <= done_q ? pad_ey[5:0] : 6'd0;
			end
			default: begin
			end
		endcase
	end

	// Status to the controller
	always_comb begin
		stat.is_start   = (req_q == REQ_START);
		stat.done       = done_q;
		stat.clear_last = (clr_addr_q == LAST_CELL);
		stat.rd_visited = rdata_q[4];
		stat.guard_zero = (guard_q == '0);
		stat.at_origin  = (cur_x_q == '0) && (cur_y_q == '0);
		stat.parent_bad = rdata_q[7];
		stat.k_wrap     = (k_q == 2'b00);
	end

endmodule

`default_nettype wire

### hdl/dmc_ctrl.sv
// Controller of the maze carver: sequences clearing, moves and backtracking.
// Issues op_t commands to dmc_datapath and owns the handshakes; uses dmc_pkg.
`default_nettype none

module dmc_ctrl
	import dmc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output op_t        op
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_LOAD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			ST_CLEAR_RST: begin
				op = OP_CLEAR;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					op      = OP_ACCEPT;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.is_start) begin
					op      = OP_START;
					state_d = ST_CLEAR;
				end else if (stat.done) begin
					state_d = ST_FINISH;
				end else begin
					op      = OP_MOVE_RD;
					state_d = ST_MOVE_CHK;
				end
			end
			ST_CLEAR: begin
				op = OP_CLEAR;
				if (stat.clear_last) state_d = ST_FINISH;
			end
			ST_MOVE_CHK: begin
				if (stat.rd_visited) begin
					state_d = ST_FINISH;
				end else begin
					op      = OP_MOVE_RDC;
					state_d = ST_MOVE_WRC;
				end
			end
			ST_MOVE_WRC: begin
				op      = OP_MOVE_WRC;
				state_d = ST_MOVE_WRN;
			end
			ST_MOVE_WRN: begin
				op      = OP_MOVE_WRN;
				state_d = ST_BT_TOP;
			end
			ST_BT_TOP: begin
				if (stat.guard_zero) begin
					op      = OP_SET_DONE;
					state_d = ST_FINISH;
				end else begin
					op      = OP_BT_RD;
					state_d = ST_BT_NB;
				end
			end
			ST_BT_NB: begin
				// stop at a free neighbor; once all four are visited, finish at the origin or else pop
				if (!stat.rd_visited) begin
					state_d = ST_FINISH;
				end else if (stat.k_wrap) begin
					if (stat.at_origin) begin
						op      = OP_SET_DONE;
						state_d = ST_FINISH;
					end else begin
						op      = OP_BT_RDC;
						state_d = ST_BT_STEP;
					end
				end else begin
					op = OP_BT_RD;
				end
			end
			ST_BT_STEP: begin
				op      = OP_BT_STEP;
				state_d = stat.parent_bad ? ST_FINISH : ST_BT_TOP;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					op      = OP_LOAD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_LOAD_OUT) |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken one");

	// An accepted transaction is dispatched next
	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DISPATCH))
		else $error("accepted transaction not dispatched");

	// Valid rises only from a load
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(op == OP_LOAD_OUT))
		else $error("result valid without a load");

	// Backtrack pops only after the fourth neighbor read
	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_BT_RDC) |-> (state_q == ST_BT_NB && stat.k_wrap))
		else $error("pop before neighbor scan finished");

endmodule

`default_nettype wire

### hdl/dfs_maze_carver.sv
// Top level of the depth-first maze carver: controller plus datapath.
// Depends on dmc_pkg, dmc_ctrl and dmc_datapath.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in_valid / in_ready   | req_type, direction
//   out     | out_valid / out_ready | move_accepted, from_x, from_y, carved_dir,
//           |                       | maze_done, exit_x, exit_y
//
// A rejected offer and a post-done offer give a result without writing the store;
// an accepted move writes both cells, then backtracks via the single-port store.
// A start request sweeps all MAX_WIDTH*MAX_HEIGHT cells of the store.
// After reset the same sweep runs with in_ready low.
// One item is in flight; the next is taken while a result waits on out_ready.
`default_nettype none

module dfs_maze_carver
	import dmc_pkg::*;
#(
	parameter int MAX_WIDTH  = DMC_MAX_WIDTH,
	parameter int MAX_HEIGHT = DMC_MAX_HEIGHT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [6:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       req_type,
	input  wire logic [1:0] direction,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            move_accepted,
	output logic [5:0]      from_x,
	output logic [5:0]      from_y,
	output logic [1:0]      carved_dir,
	output logic            maze_done,
	output logic [5:0]      exit_x,
	output logic [5:0]      exit_y
);

	op_t   op;
	stat_t stat;

	// Registers take a write in any cycle
	assign cfg_ready = 1'b1;

	dmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.op        (op)
	);

	dmc_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.stat          (stat),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_req_type   (req_type),
		.in_direction  (direction),
		.move_accepted (move_accepted),
		.from_x        (from_x),
		.from_y        (from_y),
		.carved_dir    (carved_dir),
		.maze_done     (maze_done),
		.exit_x        (exit_x),
		.exit_y        (exit_y)
	);

endmodule

`default_nettype wire

### tb/sv/dfs_maze_carver_checker.sv
// Checker for the depth-first maze carver: watches the config, request and result channels,
// predicts each result from its own copy of the maze stores and compares field by field.
// Depends on dmc_pkg.
`timescale 1ns / 1ps

module dfs_maze_carver_checker
	import dmc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [6:0] cfg_data,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic       req_type,
	input  wire logic [1:0] direction,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic       move_accepted,
	input  wire logic [5:0] from_x,
	input  wire logic [5:0] from_y,
	input  wire logic [1:0] carved_dir,
	input  wire logic       maze_done,
	input  wire logic [5:0] exit_x,
	input  wire logic [5:0] exit_y,
	output int              fail_count,
	output int              pending,
	output int              done_seen
);

	localparam int CELLS = DMC_MAX_WIDTH * DMC_MAX_HEIGHT;

	typedef struct packed {
		logic       accepted;
		logic [5:0] fx;
		logic [5:0] fy;
		logic [1:0] cdir;
		logic       done;
		logic [5:0] ex;
		logic [5:0] ey;
	} carve_rec_t;

	carve_rec_t carve_q[$];

	// Predicted maze stores
	logic [3:0] open_m[CELLS];
	logic       seen_m[CELLS];
	logic [2:0] back_m[CELLS];
	int unsigned reg_w, reg_h, act_w, act_h, cur_x, cur_y;
	int unsigned rim_exit, dead_exit;
	bit rim_ok, dead_ok, maze_fin;

	function automatic int unsigned cell_idx(int unsigned x, int unsigned y);
		return (y * DMC_MAX_WIDTH + x) % CELLS;
	endfunction

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
		if (v < 2) return 2;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// Step one cell, clamped at the grid edge
	function automatic void step_to(input int unsigned x, input int unsigned y,
			input int unsigned d, output int unsigned nx, output int unsigned ny);
		nx = x;
		ny = y;
		case (d)
			DIR_UP:    if (y > 0) ny = y - 1;
			DIR_DOWN:  if (y + 1 < act_h) ny = y + 1;
			DIR_RIGHT: if (x + 1 < act_w) nx = x + 1;
			default:   if (x > 0) nx = x - 1;
		endcase
	endfunction

	function automatic bit walled_in(int unsigned x, int unsigned y);
		int unsigned nx, ny;
		for (int d = 0; d < 4; d++) begin
			step_to(x, y, d, nx, ny);
			if (!seen_m[cell_idx(nx, ny)]) return 0;
		end
		return 1;
	endfunction

	task automatic new_maze();
		act_w = clamp_dim(reg_w, DMC_MAX_WIDTH);
		act_h = clamp_dim(reg_h, DMC_MAX_HEIGHT);
		for (int i = 0; i < CELLS; i++) begin
			open_m[i] = '0;
			seen_m[i] = 1'b0;
			back_m[i] = PARENT_NONE;
		end
		seen_m[0] = 1'b1;
		cur_x = 0;
		cur_y = 0;
		rim_exit = 0;
		dead_exit = 0;
		rim_ok = 0;
		dead_ok = 0;
		maze_fin = 0;
	endtask

	// Walk back along parent links while the walker is boxed in
	task automatic retreat();
		int unsigned guard, c, p, nx, ny;
		guard = act_w * act_h + 1;
		while (guard > 0 && walled_in(cur_x, cur_y)) begin
			c = cell_idx(cur_x, cur_y);
			guard--;
			if (cur_x == 0 && cur_y == 0) begin
				maze_fin = 1;
				return;
			end
			if (cur_x == act_w - 1 && $countones(open_m[c]) == 1) begin
				rim_exit = (cur_y << 8) | cur_x;
				rim_ok = 1;
			end
			if (!dead_ok) begin
				dead_exit = (cur_y << 8) | cur_x;
				dead_ok = 1;
			end
			p = back_m[c];
			if (p >= 4) begin
				maze_fin = 1;
				return;
			end
			step_to(cur_x, cur_y, p, nx, ny);
			cur_x = nx;
			cur_y = ny;
		end
		if (guard == 0) maze_fin = 1;
	endtask

	task automatic predict_carve(input logic req, input logic [1:0] d, output carve_rec_t r);
		int unsigned nx, ny, nc, ex;
		r = '0;
		ex = 0;
		if (req == REQ_START) begin
			new_maze();
		end else if (!maze_fin) begin
			r.fx = cur_x[5:0];
			r.fy = cur_y[5:0];
			step_to(cur_x, cur_y, d, nx, ny);
			nc = cell_idx(nx, ny);
			if (!seen_m[nc]) begin
				open_m[cell_idx(cur_x, cur_y)] |= 4'(1 << d);
				open_m[nc] |= 4'(1 << (d ^ 2'd1));
				seen_m[nc] = 1'b1;
				if (back_m[nc] == PARENT_NONE) back_m[nc] = {1'b0, d ^ 2'd1};
				cur_x = nx;
				cur_y = ny;
				r.accepted = 1'b1;
				r.cdir = d;
				retreat();
			end
		end
		if (maze_fin) ex = rim_ok ? rim_exit : (dead_ok ? dead_exit : 0);
		r.done = maze_fin;
		r.ex = ex[5:0];
		r.ey = ex[13:8];
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		done_seen = 0;
	end

	// Track config writes, predict on each request, compare each result
	always @(posedge clk or negedge arst_n) begin
		carve_rec_t r;
		if (!arst_n) begin
			reg_w = REG_RESET_DIM;
			reg_h = REG_RESET_DIM;
			new_maze();
			carve_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GRID_WIDTH) reg_w = cfg_data;
				else reg_h = cfg_data;
			end
			if (in_valid && in_ready) begin
				predict_carve(req_type, direction, r);
				carve_q.push_back(r);
			end
			if (out_valid && out_ready) begin
				if (carve_q.size() == 0) begin
					report("unexpected result transaction", 1, 0);
				end else begin
					r = carve_q.pop_front();
					if (maze_done) done_seen++;
					if (move_accepted !== r.accepted) report("move_accepted", move_accepted, r.accepted);
					if (from_x !== r.fx) report("from_x", from_x, r.fx);
					if (from_y !== r.fy) report("from_y", from_y, r.fy);
					if (carved_dir !== r.cdir) report("carved_dir", carved_dir, r.cdir);
					if (maze_done !== r.done) report("maze_done", maze_done, r.done);
					if (exit_x !== r.ex) report("exit_x", exit_x, r.ex);
					if (exit_y !== r.ey) report("exit_y", exit_y, r.ey);
				end
			end
		end
		pending = carve_q.size();
	end

endmodule

### tb/sv/dfs_maze_carver_tb.sv
// Top of the maze carver testbench: clock, reset, request and config stimulus, result stalls.
// Depends on dmc_pkg, dfs_maze_carver and dfs_maze_carver_checker.
`timescale 1ns / 1ps

module dfs_maze_carver_tb;
	import dmc_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid, cfg_ready, cfg_index;
	logic [6:0] cfg_data;
	logic       in_valid, in_ready, req_type;
	logic [1:0] direction;
	logic       out_valid, out_ready;
	logic       move_accepted, maze_done;
	logic [5:0] from_x, from_y, exit_x, exit_y;
	logic [1:0] carved_dir;
	int         fail_count, pending, done_seen;

	bit idle_on;
	bit hold_out;
	int items_sent, mazes_started;

	dfs_maze_carver u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .direction(direction),
		.out_valid(out_valid), .out_ready(out_ready), .move_accepted(move_accepted),
		.from_x(from_x), .from_y(from_y), .carved_dir(carved_dir), .maze_done(maze_done),
		.exit_x(exit_x), .exit_y(exit_y)
	);

	dfs_maze_carver_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop
	initial begin
		#30_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_out = 0;
			end else begin
				out_ready <= !(idle_on && $urandom_range(99) < 14);
			end
		end
	end

	// Drive one request transaction; valid stays up for the next one unless a gap is taken
	task automatic send_req(input logic req, input logic [1:0] d);
		if (idle_on && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		direction <= d;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		items_sent++;
		if (req == REQ_START) mazes_started++;
	endtask

	task automatic offer(input dir_t d);
		send_req(~REQ_START, d);
	endtask

	task automatic start_maze();
		send_req(REQ_START, 2'($urandom_range(3)));
	endtask

	// Drop valid and wait until every expected result is back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Write both grid registers; only called while the block is idle
	task automatic set_grid(input logic [6:0] w, input logic [6:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [6:0] pick_dim();
		logic [6:0] odd_dims[5] = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127};
		if ($urandom_range(5) == 0) return odd_dims[$urandom_range(4)];
		return 7'($urandom_range(2, 9));
	endfunction

	initial begin
		int n_offers;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_GRID_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = 1'b1;
		direction = DIR_UP;
		idle_on = 1;
		hold_out = 0;
		items_sent = 0;
		mazes_started = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default 16x16 maze, clamped and blocked moves at the origin
		offer(DIR_UP);
		offer(DIR_LEFT);
		offer(DIR_RIGHT);
		offer(DIR_LEFT);
		offer(DIR_DOWN);
		offer(DIR_UP);
		send_req(REQ_START, 2'd3);
		offer(DIR_DOWN);
		drain();

		// Directed: smallest grid, width and height below range, carved to completion
		set_grid(7'd0, 7'd1);
		send_req(REQ_START, 2'd0);
		offer(DIR_RIGHT);
		offer(DIR_RIGHT);
		offer(DIR_DOWN);
		offer(DIR_LEFT);
		offer(DIR_UP);
		offer(DIR_DOWN);
		drain();

		// Directed: widest and tallest grid, backtracking from the right edge of a two-column strip
		set_grid(7'd127, 7'd2);
		start_maze();
		repeat (3) offer(DIR_RIGHT);
		offer(DIR_DOWN);
		drain();
		set_grid(7'd2, 7'd64);
		start_maze();
		offer(DIR_DOWN);
		offer(DIR_RIGHT);
		offer(DIR_UP);
		drain();

		// Random phases of well-formed mazes with occasional noise
		for (int ph = 0; ph < 24; ph++) begin
			set_grid(pick_dim(), pick_dim());
			idle_on = (ph != 3);
			if (ph == 6) hold_out = 1;
			// Sometimes keep carving the old maze so the new size waits for a start
			if (ph == 0 || $urandom_range(3) != 0) start_maze();
			n_offers = $urandom_range(40, 70);
			for (int k = 0; k < n_offers; k++) begin
				if ($urandom_range(99) < 2) start_maze();
				else offer(dir_t'($urandom_range(3)));
			end
			drain();
		end

		drain();
		$display("Carved %0d mazes from %0d requests, %0d results reported a finished maze.",
			mazes_started, items_sent, done_seen);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
